// ===== hw/rtl/tlbclk_pkg.sv =====
// tlbclk_pkg: shared types and constants for the tlb with clock replacement
// used by tlbclk_ctrl, tlbclk_dpath and the top level; no dependencies
package tlbclk_pkg;

   localparam int CFG_BITS  = 5;
   localparam int SLOT_BITS = 4;

   localparam logic [CFG_BITS-1:0] CFG_RESET = 5'd16;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_FILL   = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic execute;
      logic load_rsp;
   } dp_cmd_type;

endpackage

// ===== hw/rtl/tlbclk_ctrl.sv =====
// tlbclk_ctrl: sequencing state machine for the tlb and the result valid flag
// depends on tlbclk_pkg; drives tlbclk_dpath through dp_cmd_type
module tlbclk_ctrl
   import tlbclk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd.load_req = 1'b0;
      cmd.execute  = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/tlbclk_dpath.sv =====
// tlbclk_dpath: tag array, marks, frame store, victim choice and result register
// depends on tlbclk_pkg; sequenced by tlbclk_ctrl
module tlbclk_dpath
   import tlbclk_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int PAGE_BITS  = 20,
   parameter int FRAME_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic                  csr_write_enable,
   input  logic [CFG_BITS-1:0]   csr_write_data,
   input  logic                  req_command,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   input  logic                  req_is_write,
   input  logic [FRAME_BITS-1:0] req_walked_frame,
   output logic                  rsp_hit,
   output logic [FRAME_BITS-1:0] rsp_frame_number,
   output logic [SLOT_BITS-1:0]  rsp_slot,
   output logic                  rsp_table_update,
   output logic                  rsp_table_dirty
);

   localparam int IDX_BITS = $clog2(ENTRIES);
   localparam int CFG_SPAN = 1 << CFG_BITS;

   logic [CFG_BITS-1:0]   csr_ff, csr_in;
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [ENTRIES-1:0]    used_ff, used_in;
   logic [PAGE_BITS-1:0]  tag_ff [ENTRIES];
   logic [FRAME_BITS-1:0] frame_mem [ENTRIES];

   logic                  cmd_ff;
   logic [PAGE_BITS-1:0]  page_ff;
   logic                  wr_ff;
   logic [FRAME_BITS-1:0] walk_ff;

   logic                  res_hit_ff;
   logic                  res_fill_ff;
   logic [IDX_BITS-1:0]   res_idx_ff;
   logic [FRAME_BITS-1:0] rd_data_ff;

   logic                  out_hit_ff;
   logic [FRAME_BITS-1:0] out_frame_ff;
   logic [SLOT_BITS-1:0]  out_slot_ff;
   logic                  out_update_ff;
   logic                  out_dirty_ff;

   logic [ENTRIES-1:0]    active;
   logic [ENTRIES-1:0]    match;
   logic [ENTRIES-1:0]    free;
   logic [ENTRIES-1:0]    unused;
   logic [IDX_BITS-1:0]   match_idx, free_idx, unused_idx, victim_idx;
   logic                  any_match, any_free, any_unused;
   logic                  is_fill;
   logic                  upd;

   // slot zero is always searched; slots at or above the register value are not
   for (genvar g = 0; g < ENTRIES; g++) begin : g_slot
      if (g == 0) begin : g_first
         assign active[g] = 1'b1;
      end else if (g < CFG_SPAN) begin : g_cfg
         assign active[g] = (csr_ff > CFG_BITS'(g));
      end else begin : g_never
         assign active[g] = 1'b0;
      end
      assign match[g]  = active[g] && valid_ff[g] && (tag_ff[g] == page_ff);
      assign free[g]   = active[g] && !valid_ff[g];
      assign unused[g] = active[g] && !used_ff[g];
   end

   // lowest set bit wins
   always_comb begin
      match_idx  = '0;
      free_idx   = '0;
      unused_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = IDX_BITS'(i);
         end
         if (free[i]) begin
            free_idx = IDX_BITS'(i);
         end
         if (unused[i]) begin
            unused_idx = IDX_BITS'(i);
         end
      end
   end

   assign any_match  = |match;
   assign any_free   = |free;
   assign any_unused = |unused;
   assign is_fill    = (cmd_ff == CMD_FILL);

   always_comb begin
      priority if (any_free) begin
         victim_idx = free_idx;
      end else if (any_unused) begin
         victim_idx = unused_idx;
      end else begin
         victim_idx = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      if (cmd.execute) begin
         if (is_fill) begin
            if (!any_free) begin
               // second-chance sweep clears marks ahead of the victim
               for (int i = 0; i < ENTRIES; i++) begin
                  if (active[i] && (!any_unused || (IDX_BITS'(i) < unused_idx))) begin
                     used_in[i] = 1'b0;
                  end
               end
            end
            valid_in[victim_idx] = 1'b1;
            used_in[victim_idx]  = 1'b1;
         end else if (any_match) begin
            used_in[match_idx] = 1'b1;
         end
      end
   end

   assign csr_in = csr_write_enable ? csr_write_data : csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff   <= CFG_RESET;
         valid_ff <= '0;
         used_ff  <= '0;
      end else begin
         csr_ff   <= csr_in;
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && is_fill) begin
         tag_ff[victim_idx] <= page_ff;
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (cmd.execute && is_fill) begin
         frame_mem[victim_idx] <= walk_ff;
      end
      if (cmd.execute) begin
         rd_data_ff <= frame_mem[match_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff  <= req_command;
         page_ff <= req_page_number;
         wr_ff   <= req_is_write;
         walk_ff <= req_walked_frame;
      end
      if (cmd.execute) begin
         res_hit_ff  <= !is_fill && any_match;
         res_fill_ff <= is_fill;
         res_idx_ff  <= is_fill ? victim_idx : match_idx;
      end
   end

   assign upd = res_hit_ff || res_fill_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_hit_ff    <= res_hit_ff;
         out_update_ff <= upd;
         out_dirty_ff  <= upd && wr_ff;
         out_slot_ff   <= upd ? SLOT_BITS'(res_idx_ff) : '0;
         if (res_fill_ff) begin
            out_frame_ff <= walk_ff;
         end else if (res_hit_ff) begin
            out_frame_ff <= rd_data_ff;
         end else begin
            out_frame_ff <= '0;
         end
      end
   end

   assign rsp_hit          = out_hit_ff;
   assign rsp_frame_number = out_frame_ff;
   assign rsp_slot         = out_slot_ff;
   assign rsp_table_update = out_update_ff;
   assign rsp_table_dirty  = out_dirty_ff;

endmodule

// ===== hw/rtl/tlb_lookup_with_clock_replacement.sv =====
// Fully associative TLB with second-chance (clock) replacement. Each beat is
// registered, then the EXEC state does the parallel tag compare, victim choice,
// mark updates and the frame store access, then the result loads into the output
// register. The output register lets the next beat enter while a result waits;
// req_stall stays high until a beat's result loads, so beats do not overlap.
// Lookups hit the lowest matching slot; fills take the lowest invalid slot, else
// sweep used marks from slot 0. csr_write_data sets the number of slots in use
// (0 counts as 1, values above ENTRIES count as ENTRIES); write it only when idle.
// depends on tlbclk_pkg, tlbclk_ctrl and tlbclk_dpath
module tlb_lookup_with_clock_replacement
   import tlbclk_pkg::*;
#(
   parameter int ENTRIES    = 16,
   parameter int PAGE_BITS  = 20,
   parameter int FRAME_BITS = 20
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CFG_BITS-1:0]   csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [PAGE_BITS-1:0]  req_page_number,
   input  logic                  req_is_write,
   input  logic [FRAME_BITS-1:0] req_walked_frame,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic [FRAME_BITS-1:0] rsp_frame_number,
   output logic [SLOT_BITS-1:0]  rsp_slot,
   output logic                  rsp_table_update,
   output logic                  rsp_table_dirty
);

   dp_cmd_type cmd;

   tlbclk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   tlbclk_dpath #(
      .ENTRIES    (ENTRIES),
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_page_number  (req_page_number),
      .req_is_write     (req_is_write),
      .req_walked_frame (req_walked_frame),
      .rsp_hit          (rsp_hit),
      .rsp_frame_number (rsp_frame_number),
      .rsp_slot         (rsp_slot),
      .rsp_table_update (rsp_table_update),
      .rsp_table_dirty  (rsp_table_dirty)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("beat accepted while previous beat still in progress");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   a_hit_updates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> rsp_table_update)
      else $error("hit without table update");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_table_update) |->
         (rsp_frame_number == '0 && rsp_slot == '0 && !rsp_table_dirty && !rsp_hit))
      else $error("miss result carries nonzero fields");
`endif

endmodule
